// File: src/point_polygon_distance_defines.svh
// Assertion macros shared by the point-to-polygon distance block
`ifndef POINT_POLYGON_DISTANCE_DEFINES_SVH
`define POINT_POLYGON_DISTANCE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PPD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppd assertion failed");

// next-cycle implication, disabled during reset
`define PPD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppd assertion failed");

`endif

// File: src/ppd_pkg.sv
// Types and constants of the point-to-polygon distance block
`default_nettype none
package ppd_pkg;

	typedef enum logic [1:0] {
		FN_CLEAR  = 2'd0,
		FN_APPEND = 2'd1,
		FN_QUERY  = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_DIV,
		ST_ROT,
		ST_SQRT
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	localparam int unsigned CoordW  = 16;
	localparam int unsigned DistW   = 17;
	localparam int unsigned ProdW   = 36;
	localparam int unsigned SqW     = 34;
	localparam int unsigned NumW    = 66;
	localparam int unsigned MinPoly = 3;

endpackage
`default_nettype wire

// File: src/ppd_cell.sv
// One vertex cell of the rotating vertex chain
`default_nettype none
module ppd_cell (
	input  logic                   clk,
	input  ppd_pkg::cell_ctl_t     ctl,
	input  logic signed [15:0]     ld_x,
	input  logic signed [15:0]     ld_y,
	input  logic signed [15:0]     nb_x,
	input  logic signed [15:0]     nb_y,
	output logic signed [15:0]     x,
	output logic signed [15:0]     y
);
	import ppd_pkg::*;

	logic signed [CoordW-1:0] x_q, y_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= ld_x;
			y_q <= ld_y;
		end else if (ctl.shift) begin
			// take the neighbour's vertex
			x_q <= nb_x;
			y_q <= nb_y;
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule
`default_nettype wire

// File: src/point_polygon_distance.sv
// Top level: vertex chain, edge sequencer, divider and root unit
//
// Command channel: an item is transferred when start is high and busy is low.
// func selects clear, append or query; coord_x/coord_y carry Q8.8 values.
// Result channel: done is high for one cycle with inside_res, distance and
// status; every item gives exactly one result, and it cannot be held off.
// Clear and append leave the block idle: the result follows the next cycle
// and a new item may be transferred at once.
// A query walks each of the n stored edges over the vertex chain, which
// rotates one cell per edge and then on to MAX_VERTICES rotations in all.
// An edge ends after its multiplier steps when the nearest point is a vertex,
// and goes on through the divider when it lies inside the segment. Then the
// root step runs unless the point is inside.
// An empty polygon answers a query in the next cycle.
// Reset empties the polygon and returns the sequencer to idle; vertex cells
// are not cleared, since only written cells are read.
`default_nettype none
`include "point_polygon_distance_defines.svh"
module point_polygon_distance #(
	parameter int unsigned MAX_VERTICES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	output logic               done,
	output logic               inside_res,
	output logic [16:0]        distance,
	output logic               status
);
	import ppd_pkg::*;

	localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
	localparam int unsigned NX = (MAX_VERTICES > 1) ? 1 : 0;

	state_t state_q, state_d;

	logic [CW-1:0] count_q, idx_q;
	logic [3:0]    step_q;
	logic [5:0]    cnt_q;
	logic signed [CoordW-1:0] px_q, py_q, v0x_q, v0y_q;
	logic signed [ProdW-1:0]  len2_q, dot_q, cr_q, lhs_q, acc_q;
	logic [32:0]     mag_q;
	logic [NumW-1:0] num_q;
	logic [SqW-1:0]  rem_q, dl_q, minq_q;
	logic            seg_q, ptb_q, par_q;
	logic [DistW-1:0] root_q, sbit_q;
	logic            done_q, inside_q, status_q;
	logic [DistW-1:0] dist_q;

	logic signed [CoordW-1:0] cx [MAX_VERTICES];
	logic signed [CoordW-1:0] cy [MAX_VERTICES];

	logic acc_in, rot;
	assign busy   = (state_q != ST_IDLE);
	assign acc_in = start && !busy;

	// vertex chain
	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
		cell_ctl_t ctl;
		assign ctl.load  = acc_in && (func == FN_APPEND) && (count_q == CW'(k));
		assign ctl.shift = rot;
		ppd_cell u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.ld_x (coord_x),
			.ld_y (coord_y),
			.nb_x (cx[(k + 1) % MAX_VERTICES]),
			.nb_y (cy[(k + 1) % MAX_VERTICES]),
			.x    (cx[k]),
			.y    (cy[k])
		);
	end

	// edge geometry
	logic [CW:0] idx_nx1;
	logic        at_n, at_m;
	assign idx_nx1 = {1'b0, idx_q} + (CW+1)'(1);
	assign at_n    = (idx_nx1 == {1'b0, count_q});
	assign at_m    = (idx_nx1 == (CW+1)'(MAX_VERTICES));

	logic signed [CoordW-1:0] hx, hy, nx, ny;
	assign hx = cx[0];
	assign hy = cy[0];
	assign nx = at_n ? v0x_q : cx[NX];
	assign ny = at_n ? v0y_q : cy[NX];

	logic signed [16:0] ax, ay, bx, by, qx, qy, ex, ey;
	assign ax = {px_q[15], px_q} - {hx[15], hx};
	assign ay = {py_q[15], py_q} - {hy[15], hy};
	assign bx = {nx[15], nx} - {hx[15], hx};
	assign by = {ny[15], ny} - {hy[15], hy};
	assign qx = {px_q[15], px_q} - {nx[15], nx};
	assign qy = {py_q[15], py_q} - {ny[15], ny};
	assign ex = ptb_q ? qx : ax;
	assign ey = ptb_q ? qy : ay;

	logic signed [17:0] nbx, nby;
	assign nbx = -{bx[16], bx};
	assign nby = -{by[16], by};

	logic [DistW-1:0] cand;
	assign cand = root_q | sbit_q;

	// shared multiplier
	logic signed [17:0]      mul_a, mul_b;
	logic signed [ProdW-1:0] prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_EDGE: begin
				case (step_q)
					4'd0: begin mul_a = {bx[16], bx}; mul_b = {bx[16], bx}; end
					4'd1: begin mul_a = {by[16], by}; mul_b = {by[16], by}; end
					4'd2: begin mul_a = {ax[16], ax}; mul_b = {bx[16], bx}; end
					4'd3: begin mul_a = {ay[16], ay}; mul_b = {by[16], by}; end
					4'd4: begin mul_a = {ax[16], ax}; mul_b = {by[16], by}; end
					4'd5: begin mul_a = {ay[16], ay}; mul_b = {bx[16], bx}; end
					4'd6: begin mul_a = {qx[16], qx}; mul_b = nby; end
					4'd7: begin mul_a = nbx; mul_b = {qy[16], qy}; end
					4'd8: begin
						if (seg_q) begin
							mul_a = {1'b0, mag_q[32:16]}; mul_b = {1'b0, mag_q[32:16]};
						end else begin
							mul_a = {ex[16], ex}; mul_b = {ex[16], ex};
						end
					end
					4'd9: begin
						if (seg_q) begin
							mul_a = {1'b0, mag_q[32:16]}; mul_b = {2'b0, mag_q[15:0]};
						end else begin
							mul_a = {ey[16], ey}; mul_b = {ey[16], ey};
						end
					end
					4'd10: begin mul_a = {2'b0, mag_q[15:0]}; mul_b = {2'b0, mag_q[15:0]}; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_SQRT: begin
				mul_a = {1'b0, cand};
				mul_b = {1'b0, cand};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// per-edge squared distance and its end
	logic [33:0] r2;
	logic        ge;
	logic [NumW-1:0] nfull;
	logic        edge_end, go_fin;
	logic [SqW-1:0] qnew;
	logic signed [ProdW-1:0] pt_sum;

	assign r2     = {rem_q[32:0], dl_q[33]};
	assign ge     = (r2 >= {1'b0, len2_q[32:0]});
	assign nfull  = num_q + NumW'(prod[33:0]);
	assign pt_sum = acc_q + prod;

	always_comb begin
		edge_end = 1'b0;
		qnew     = '0;
		if (state_q == ST_EDGE && step_q == 4'd9 && !seg_q) begin
			edge_end = 1'b1;
			qnew     = pt_sum[SqW-1:0];
		end else if (state_q == ST_DIV && cnt_q == 6'd33) begin
			edge_end = 1'b1;
			qnew     = {dl_q[32:0], ge};
		end
	end

	assign rot    = edge_end || (state_q == ST_ROT);
	assign go_fin = (edge_end && at_n && at_m) || (state_q == ST_ROT && at_m);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_in && func == FN_QUERY && count_q != '0) begin
					state_d = ST_EDGE;
				end
			end
			ST_EDGE: begin
				if (step_q == 4'd10) begin
					state_d = ST_DIV;
				end else if (edge_end && at_n) begin
					state_d = at_m ? (par_q ? ST_IDLE : ST_SQRT) : ST_ROT;
				end
			end
			ST_DIV: begin
				if (edge_end) begin
					if (at_n) begin
						state_d = at_m ? (par_q ? ST_IDLE : ST_SQRT) : ST_ROT;
					end else begin
						state_d = ST_EDGE;
					end
				end
			end
			ST_ROT: begin
				if (at_m) begin
					state_d = par_q ? ST_IDLE : ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (sbit_q[0]) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			inside_q <= 1'b0;
			dist_q   <= '0;
			status_q <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			inside_q <= 1'b0;
			dist_q   <= '0;
			status_q <= 1'b0;
			if (acc_in) begin
				case (func)
					FN_CLEAR: begin
						count_q <= '0;
						done_q  <= 1'b1;
					end
					FN_APPEND: begin
						done_q <= 1'b1;
						if (count_q == CW'(MAX_VERTICES)) begin
							status_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
					FN_QUERY: begin
						if (count_q == '0) begin
							done_q <= 1'b1;
						end
					end
					default: done_q <= 1'b1;
				endcase
			end
			if (go_fin && par_q) begin
				done_q   <= 1'b1;
				inside_q <= 1'b1;
			end
			if (state_q == ST_SQRT && sbit_q[0]) begin
				done_q <= 1'b1;
				dist_q <= ($unsigned(prod) <= {2'b0, minq_q}) ? cand : root_q;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc_in && func == FN_QUERY) begin
			px_q   <= coord_x;
			py_q   <= coord_y;
			v0x_q  <= cx[0];
			v0y_q  <= cy[0];
			idx_q  <= '0;
			step_q <= '0;
			par_q  <= 1'b0;
			minq_q <= '1;
		end
		case (state_q)
			ST_EDGE: begin
				step_q <= step_q + 4'd1;
				case (step_q)
					4'd0: len2_q <= prod;
					4'd1: len2_q <= len2_q + prod;
					4'd2: dot_q  <= prod;
					4'd3: dot_q  <= dot_q + prod;
					4'd4: cr_q   <= prod;
					4'd5: cr_q   <= cr_q - prod;
					4'd6: begin
						lhs_q <= prod;
						mag_q <= cr_q[ProdW-1] ? 33'(-cr_q) : cr_q[32:0];
					end
					4'd7: begin
						// crossing test for this edge, strict compares
						if (((ny > py_q) != (hy > py_q)) && count_q >= CW'(MinPoly) &&
						    ((by < 0) ? (lhs_q < prod) : (lhs_q > prod))) begin
							par_q <= !par_q;
						end
						if (len2_q == '0 || dot_q <= 0) begin
							seg_q <= 1'b0;
							ptb_q <= 1'b0;
						end else if (dot_q >= len2_q) begin
							seg_q <= 1'b0;
							ptb_q <= 1'b1;
						end else begin
							seg_q <= 1'b1;
							ptb_q <= 1'b0;
						end
					end
					4'd8: begin
						acc_q <= prod;
						num_q <= {prod[33:0], 32'b0};
					end
					4'd9: begin
						num_q <= num_q + (NumW'(prod[33:0]) << 17);
					end
					4'd10: begin
						rem_q <= {2'b0, nfull[65:34]};
						dl_q  <= nfull[33:0];
						cnt_q <= '0;
					end
					default: step_q <= '0;
				endcase
			end
			ST_DIV: begin
				rem_q <= ge ? (r2 - {1'b0, len2_q[32:0]}) : r2;
				dl_q  <= {dl_q[32:0], ge};
				cnt_q <= cnt_q + 6'd1;
			end
			ST_ROT: begin
				idx_q <= idx_nx1[CW-1:0];
			end
			ST_SQRT: begin
				if ($unsigned(prod) <= {2'b0, minq_q}) begin
					root_q <= cand;
				end
				sbit_q <= sbit_q >> 1;
			end
			default: ;
		endcase
		if (edge_end) begin
			idx_q  <= idx_nx1[CW-1:0];
			step_q <= '0;
			if (qnew < minq_q) begin
				minq_q <= qnew;
			end
		end
		if (go_fin) begin
			root_q <= '0;
			sbit_q <= {1'b1, {(DistW-1){1'b0}}};
		end
	end

	assign done       = done_q;
	assign inside_res = inside_q;
	assign distance   = dist_q;
	assign status     = status_q;

	`PPD_ASSERT_IMP(a_inside_zero, done && inside_res, distance == '0)
	`PPD_ASSERT_IMP(a_drop_plain, done && status, !inside_res && distance == '0)
	`PPD_ASSERT_NXT(a_accept_moves, start && !busy, done || busy)

endmodule
`default_nettype wire
